// File: src/dmseg_pkg.sv
// shared types, codes and reset values for the dual motion sensor event gate
package dmseg_pkg;

  localparam int unsigned NUM_CH = 2;
  localparam int unsigned CH_FRONT = 0;
  localparam int unsigned CH_BACK = 1;

  // function codes
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_CHECK   = 3'd1;
  localparam logic [2:0] FUNC_PUBLISH = 3'd2;
  localparam logic [2:0] FUNC_ACK     = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_FRONT_EN = 3'd0;
  localparam logic [2:0] CFG_BACK_EN  = 3'd1;
  localparam logic [2:0] CFG_MIN_GAP  = 3'd2;
  localparam logic [2:0] CFG_THROTTLE = 3'd3;
  localparam logic [2:0] CFG_LOCKOUT  = 3'd4;

  localparam logic [30:0] MIN_GAP_RST  = 31'd1000;
  localparam logic [30:0] THROTTLE_RST = 31'd60000;
  localparam logic [30:0] LOCKOUT_RST  = 31'd60000;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_ms;
    logic [1:0]  fire_mask;
    logic [15:0] raw_hits;
    logic [31:0] ack_id;
  } item_t;

  typedef struct packed {
    logic [1:0]  acc_mask;
    logic        pending;
    logic [31:0] evt_id;
    logic [15:0] event_count;
    logic [31:0] first_time;
    logic [31:0] last_time;
    logic [1:0]  source_mask;
    logic        publish_allowed;
    logic        dropped;
  } result_t;

  typedef struct packed {
    logic        front_enable;
    logic        back_enable;
    logic [30:0] min_gap_ms;
    logic [30:0] throttle_ms;
    logic [30:0] lockout_ms;
  } cfg_t;

  typedef struct packed {
    logic                     pending;
    logic [31:0]              id;
    logic [15:0]              count;
    logic [31:0]              first;
    logic [31:0]              last;
    logic [1:0]               sources;
    logic [31:0]              next_num;
    logic [NUM_CH-1:0][31:0]  last_accept;
    logic [NUM_CH-1:0][31:0]  last_publish;
    logic [NUM_CH-1:0][31:0]  ignore_until;
  } state_t;

  // per-channel timing status
  typedef struct packed {
    logic locked;
    logic gap_ok;
    logic thr_ok;
  } chan_stat_t;

endpackage

// File: src/dmseg_if.sv
// valid/ready channels for input items and result items
interface dmseg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] now_ms;
  logic [1:0]  fire_mask;
  logic [15:0] raw_hits;
  logic [31:0] ack_id;

  modport source (output valid, func, now_ms, fire_mask, raw_hits, ack_id, input ready);
  modport sink (input valid, func, now_ms, fire_mask, raw_hits, ack_id, output ready);
endinterface

interface dmseg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  acc_mask;
  logic        pending;
  logic [31:0] evt_id;
  logic [15:0] event_count;
  logic [31:0] first_time;
  logic [31:0] last_time;
  logic [1:0]  source_mask;
  logic        publish_allowed;
  logic        dropped;

  modport source (output valid, acc_mask, pending, evt_id, event_count, first_time,
                  last_time, source_mask, publish_allowed, dropped, input ready);
  modport sink (input valid, acc_mask, pending, evt_id, event_count, first_time,
                last_time, source_mask, publish_allowed, dropped, output ready);
endinterface

// File: src/dmseg_chan.sv
// per-channel wraparound-safe time compares: lockout, hit gap, publish throttle
module dmseg_chan
  import dmseg_pkg::*;
(
  input  logic [31:0] now_ms,
  input  logic [31:0] last_accept,
  input  logic [31:0] last_publish,
  input  logic [31:0] ignore_until,
  input  logic [30:0] min_gap_ms,
  input  logic [30:0] throttle_ms,
  output chan_stat_t  stat
);

  logic [31:0] d_lock;
  logic [31:0] d_gap;
  logic [31:0] d_thr;

  assign d_lock = now_ms - ignore_until;
  assign d_gap  = now_ms - last_accept;
  assign d_thr  = now_ms - last_publish;

  // zero stored time means never accepted / never published
  assign stat.locked = d_lock[31];
  assign stat.gap_ok = (last_accept == 32'd0) || (!d_gap[31] && (d_gap[30:0] >= min_gap_ms));
  assign stat.thr_ok = (last_publish == 32'd0) || (!d_thr[31] && (d_thr[30:0] >= throttle_ms));

endmodule

// File: src/dmseg_core.sv
// next-state and result logic for one item
module dmseg_core
  import dmseg_pkg::*;
(
  input  item_t   item,
  input  state_t  st,
  input  cfg_t    cfg,
  output state_t  st_nxt,
  output result_t res
);

  chan_stat_t [NUM_CH-1:0] stat;
  logic [1:0] tick_mask;
  logic [1:0] acc;
  logic [1:0] add;
  logic       allow;
  logic       dropped;

  for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
    dmseg_chan u_chan (
      .now_ms       (item.now_ms),
      .last_accept  (st.last_accept[i]),
      .last_publish (st.last_publish[i]),
      .ignore_until (st.ignore_until[i]),
      .min_gap_ms   (cfg.min_gap_ms),
      .throttle_ms  (cfg.throttle_ms),
      .stat         (stat[i])
    );
  end

  always_comb begin
    tick_mask = item.fire_mask & {cfg.back_enable, cfg.front_enable};
    if (item.raw_hits == 16'd0) begin
      tick_mask = 2'b00;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      acc[i] = tick_mask[i] && !stat[i].locked && stat[i].gap_ok;
    end
    add = {1'b0, acc[CH_FRONT]} + {1'b0, acc[CH_BACK]};
    allow = |(st.sources & {stat[CH_BACK].thr_ok, stat[CH_FRONT].thr_ok});
  end

  always_comb begin
    st_nxt  = st;
    dropped = 1'b0;
    unique case (item.func)
      FUNC_TICK: begin
        if (acc != 2'b00) begin
          if (!st.pending) begin
            st_nxt.pending  = 1'b1;
            st_nxt.id       = st.next_num;
            st_nxt.next_num = st.next_num + 32'd1;
            st_nxt.count    = 16'd0;
            st_nxt.first    = item.now_ms;
            st_nxt.sources  = 2'b00;
          end
          st_nxt.count   = st_nxt.count + {14'd0, add};
          st_nxt.last    = item.now_ms;
          st_nxt.sources = st_nxt.sources | acc;
          for (int i = 0; i < NUM_CH; i++) begin
            if (acc[i]) begin
              st_nxt.last_accept[i] = item.now_ms;
            end
          end
        end
      end
      FUNC_CHECK: begin
        if (st.pending && !allow) begin
          dropped        = 1'b1;
          st_nxt.pending = 1'b0;
          st_nxt.id      = 32'd0;
          st_nxt.count   = 16'd0;
          st_nxt.first   = 32'd0;
          st_nxt.last    = 32'd0;
          st_nxt.sources = 2'b00;
        end
      end
      FUNC_PUBLISH: begin
        if (st.pending) begin
          for (int i = 0; i < NUM_CH; i++) begin
            if (st.sources[i]) begin
              st_nxt.last_publish[i] = item.now_ms;
              st_nxt.ignore_until[i] = item.now_ms + {1'b0, cfg.lockout_ms};
            end
          end
        end
      end
      FUNC_ACK: begin
        if (st.pending && (st.id == item.ack_id)) begin
          st_nxt.pending = 1'b0;
          st_nxt.id      = 32'd0;
          st_nxt.count   = 16'd0;
          st_nxt.first   = 32'd0;
          st_nxt.last    = 32'd0;
          st_nxt.sources = 2'b00;
        end
      end
      FUNC_CLEAR: begin
        st_nxt.pending     = 1'b0;
        st_nxt.id          = 32'd0;
        st_nxt.count       = 16'd0;
        st_nxt.first       = 32'd0;
        st_nxt.last        = 32'd0;
        st_nxt.sources     = 2'b00;
        st_nxt.last_accept = '0;
      end
      default: begin
      end
    endcase
  end

  // results show the state after the step
  always_comb begin
    res.acc_mask        = (item.func == FUNC_TICK) ? acc : 2'b00;
    res.pending         = st_nxt.pending;
    res.evt_id          = st_nxt.id;
    res.event_count     = st_nxt.count;
    res.first_time      = st_nxt.first;
    res.last_time       = st_nxt.last;
    res.source_mask     = st_nxt.sources;
    res.publish_allowed = (item.func == FUNC_CHECK) && st.pending && allow;
    res.dropped         = dropped;
  end

endmodule

// File: src/dual_motion_sensor_event_gate.sv
// Dual motion sensor event gate: qualifies front/back sensor hits and keeps one
// pending event in an outbox. Each transfer on in_ch is captured in an input
// register; its effect on the state and its single result are computed from
// that register and written together into the state and the result register.
// A new item can be taken every cycle while in_ch is not stalled. The result
// register is the only buffering on out_ch, so in_ch stalls only while a result
// waits and the input register is also full.
// Configuration writes on cfg_* take effect at once and belong in idle periods.
module dual_motion_sensor_event_gate
  import dmseg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  dmseg_in_if.sink     in_ch,
  dmseg_out_if.source  out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  item_t   item_r;
  logic    item_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    res_valid_r;
  logic    advance;

  // the staged item moves on when the result register is free or being drained
  assign advance      = item_valid_r && (!res_valid_r || out_ch.ready);
  assign in_ch.ready  = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_enable <= 1'b1;
      cfg_r.back_enable  <= 1'b1;
      cfg_r.min_gap_ms   <= MIN_GAP_RST;
      cfg_r.throttle_ms  <= THROTTLE_RST;
      cfg_r.lockout_ms   <= LOCKOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRONT_EN: cfg_r.front_enable <= cfg_wdata[0];
        CFG_BACK_EN:  cfg_r.back_enable  <= cfg_wdata[0];
        CFG_MIN_GAP:  cfg_r.min_gap_ms   <= cfg_wdata;
        CFG_THROTTLE: cfg_r.throttle_ms  <= cfg_wdata;
        CFG_LOCKOUT:  cfg_r.lockout_ms   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      item_r.func      <= in_ch.func;
      item_r.now_ms    <= in_ch.now_ms;
      item_r.fire_mask <= in_ch.fire_mask;
      item_r.raw_hits  <= in_ch.raw_hits;
      item_r.ack_id    <= in_ch.ack_id;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
      st_r         <= '{next_num: 32'd1, default: '0};
    end else begin
      if (in_ch.ready) begin
        item_valid_r <= in_ch.valid;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  dmseg_core u_core (
    .item   (item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign out_ch.valid           = res_valid_r;
  assign out_ch.acc_mask        = res_r.acc_mask;
  assign out_ch.pending         = res_r.pending;
  assign out_ch.evt_id          = res_r.evt_id;
  assign out_ch.event_count     = res_r.event_count;
  assign out_ch.first_time      = res_r.first_time;
  assign out_ch.last_time       = res_r.last_time;
  assign out_ch.source_mask     = res_r.source_mask;
  assign out_ch.publish_allowed = res_r.publish_allowed;
  assign out_ch.dropped         = res_r.dropped;

endmodule
